// ===== rtl/core/sfd_pkg.sv =====
// Package for the serial frame deframer: result event codes, field widths
// and the result word type. No dependencies.
package sfd_pkg;

    localparam int BYTE_W = 8;
    localparam int KIND_W = 2;

    localparam logic [KIND_W-1:0] EV_DATA      = 2'd0;
    localparam logic [KIND_W-1:0] EV_OK        = 2'd1;
    localparam logic [KIND_W-1:0] EV_BAD_SUM   = 2'd2;
    localparam logic [KIND_W-1:0] EV_BAD_START = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] event_kind;
        logic [BYTE_W-1:0] msg_type;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] payload_index;
        logic [BYTE_W-1:0] computed_sum;
    } t_result;

endpackage

// ===== rtl/core/sfd_in_if.sv =====
// Valid/ready channel that carries received bytes into the deframer.
// Depends on sfd_pkg.
interface sfd_in_if import sfd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/sfd_out_if.sv =====
// Valid/ready channel that carries deframer events out of the block.
// Depends on sfd_pkg.
interface sfd_out_if import sfd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] event_kind;
    logic [BYTE_W-1:0] msg_type;
    logic [BYTE_W-1:0] payload_byte;
    logic [BYTE_W-1:0] payload_index;
    logic [BYTE_W-1:0] computed_sum;

    modport source (output valid, output event_kind, output msg_type, output payload_byte,
                    output payload_index, output computed_sum, input ready);
    modport sink   (input valid, input event_kind, input msg_type, input payload_byte,
                    input payload_index, input computed_sum, output ready);
endinterface

// ===== rtl/core/serial_frame_deframer.sv =====
// Serial frame deframer top level; uses sfd_pkg, sfd_in_if and sfd_out_if.
// Throughput: one word per cycle when not stalled; frame state is updated in the accept cycle.
// Each event is registered in the output register or the skid entry before it appears.
// An output register plus one skid entry let input words keep flowing while a
// result waits; the input stalls only when both are full.
// Reset (synchronous, active low) returns to idle, clears the start marker and empties the output.
module serial_frame_deframer import sfd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [BYTE_W-1:0] i_cfg_data,
    sfd_in_if.sink            i_rx,
    sfd_out_if.source         o_ev
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_LEN  = 3'd1;
    localparam logic [2:0] PH_TYPE = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_SUM  = 3'd4;

    logic [BYTE_W-1:0] r_start_marker;
    logic [2:0]        r_phase, n_phase;
    logic [BYTE_W-1:0] r_bytes_left, n_bytes_left;
    logic [BYTE_W-1:0] r_frame_type, n_frame_type;
    logic [BYTE_W-1:0] r_running_sum, n_running_sum;
    logic [BYTE_W-1:0] r_index_count, n_index_count;

    logic              r_out_valid, n_out_valid;
    logic              r_skid_valid, n_skid_valid;
    t_result           r_out, n_out;
    t_result           r_skid, n_skid;

    logic              accept;
    logic              emit;
    t_result           result;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] left_dec;
    logic [BYTE_W-1:0] sum_add;
    logic              take;

    assign b        = i_rx.rx_byte;
    assign accept   = i_rx.valid && i_rx.ready;
    assign left_dec = r_bytes_left - 1'b1;
    assign sum_add  = r_running_sum + b;

    always_comb begin
        n_phase       = r_phase;
        n_bytes_left  = r_bytes_left;
        n_frame_type  = r_frame_type;
        n_running_sum = r_running_sum;
        n_index_count = r_index_count;
        emit          = 1'b0;
        result        = '0;
        unique case (r_phase)
            PH_LEN: begin
                n_bytes_left = b;
                n_phase      = PH_TYPE;
            end
            PH_TYPE: begin
                if (r_bytes_left == '0) begin
                    // Zero length: the header is dropped without an event.
                    n_phase = PH_IDLE;
                end else begin
                    n_frame_type  = b;
                    n_running_sum = b;
                    n_index_count = '0;
                    n_bytes_left  = left_dec;
                    n_phase       = (left_dec == '0) ? PH_SUM : PH_DATA;
                end
            end
            PH_DATA: begin
                n_running_sum = sum_add;
                n_index_count = r_index_count + 1'b1;
                n_bytes_left  = left_dec;
                if (left_dec == '0) begin
                    n_phase = PH_SUM;
                end
                emit                 = 1'b1;
                result.event_kind    = EV_DATA;
                result.msg_type      = r_frame_type;
                result.payload_byte  = b;
                result.payload_index = r_index_count;
                result.computed_sum  = sum_add;
            end
            PH_SUM: begin
                n_phase              = PH_IDLE;
                emit                 = 1'b1;
                result.event_kind    = (b == r_running_sum) ? EV_OK : EV_BAD_SUM;
                result.msg_type      = r_frame_type;
                result.payload_byte  = b;
                result.computed_sum  = r_running_sum;
            end
            default: begin
                // Idle, and any unused phase code behaves as idle.
                if (b == r_start_marker) begin
                    n_phase = PH_LEN;
                end else begin
                    n_phase             = PH_IDLE;
                    emit                = 1'b1;
                    result.event_kind   = EV_BAD_START;
                    result.payload_byte = b;
                end
            end
        endcase
    end

    // Output register with one skid entry behind it.
    assign take = r_out_valid && o_ev.ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (take || !r_out_valid) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = accept && emit;
                n_skid       = result;
            end else begin
                n_out_valid = accept && emit;
                n_out       = result;
            end
        end else if (accept && emit) begin
            n_skid_valid = 1'b1;
            n_skid       = result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= '0;
            r_phase        <= PH_IDLE;
            r_bytes_left   <= '0;
            r_frame_type   <= '0;
            r_running_sum  <= '0;
            r_index_count  <= '0;
            r_out_valid    <= 1'b0;
            r_skid_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_start_marker <= i_cfg_data;
            end
            if (accept) begin
                r_phase       <= n_phase;
                r_bytes_left  <= n_bytes_left;
                r_frame_type  <= n_frame_type;
                r_running_sum <= n_running_sum;
                r_index_count <= n_index_count;
            end
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign i_rx.ready         = !r_skid_valid;
    assign o_ev.valid         = r_out_valid;
    assign o_ev.event_kind    = r_out.event_kind;
    assign o_ev.msg_type      = r_out.msg_type;
    assign o_ev.payload_byte  = r_out.payload_byte;
    assign o_ev.payload_index = r_out.payload_index;
    assign o_ev.computed_sum  = r_out.computed_sum;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a word while the output register is empty");

    a_sum_gives_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_phase == PH_SUM) |=> r_out_valid)
        else $error("checksum byte produced no frame end event");

    a_data_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_bytes_left != '0))
        else $error("payload phase entered with no bytes left");

    a_len_to_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_phase == PH_LEN) |=> (r_phase == PH_TYPE))
        else $error("length byte did not advance to the type phase");

endmodule
